// ===== rtl/core/pnu_pkg.sv =====
// Shared constants, types and helpers for the packed nearest-neighbor 2x upsampler.
package pnu_pkg;

  localparam int MAX_WIDTH   = 62;
  localparam int SAMPLE_BITS = 16;
  localparam int CHAN_LIMIT  = 1024;
  localparam int Q_DEPTH     = 2;

  localparam int WIDTH_BITS = 6;
  localparam int CCNT_BITS  = 11;
  localparam int CHAN_BITS  = 10;
  localparam int ADDR_BITS  = 24;
  localparam int HALF_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int IDX_BITS   = $clog2(MAX_WIDTH);
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic [HALF_BITS-1:0] SAMPLE_MASK =
    HALF_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);

  typedef enum logic {
    REG_ROW_WIDTH  = 1'b0,
    REG_CHAN_COUNT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [HALF_BITS-1:0]  sample_a;
    logic [HALF_BITS-1:0]  sample_b;
    logic                  two;
    logic [IDX_BITS-1:0]   idx_a;
    logic [WIDTH_BITS-1:0] size;
    logic [ADDR_BITS-1:0]  row_base;
    logic                  replay;
    logic                  done;
  } cmd_t;

endpackage

// ===== rtl/core/packed_nearest_upsample_2x.sv =====
// Top level of the packed nearest-neighbor 2x upsampler.
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  s_tdata[31:0] in_word
// m_*      out  m_tvalid / m_tready  m_tdata[23:0] out_addr, [55:24] out_word;
//                                    m_tlast run_last; m_tuser map_done
// APB      in   psel / penable       reg 0 row_width at 0x0, reg 1 channel_count at 0x4
//
// The front end takes one request per cycle while the two-entry queue has room.
// The back end delivers one result per cycle when not stalled: one or two per request and,
// at each row end, a line store read followed by one replay result per sample of the row.
// The single output register and the line store read port set the result rate.
// Reset is synchronous and active high; a register write restarts the map at its origin.
// Stalls on the result side fill the queue and then hold off new requests.
module packed_nearest_upsample_2x (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] in_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [23:0] out_addr, [55:24] out_word
  output logic        m_tlast,
  output logic        m_tuser,   // [0] map_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pnu_pkg::*;

  cmd_t                 front_cmd;
  cmd_t                 head_cmd;
  logic                 q_full;
  logic                 head_valid;
  logic                 pop;
  logic                 in_fire;
  logic [ADDR_BITS-1:0] out_addr;
  logic [WORD_BITS-1:0] out_word;

  assign pready   = 1'b1;
  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;
  assign m_tdata  = {out_word, out_addr};

  pnu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .in_fire(in_fire),
    .in_word(s_tdata),
    .cmd    (front_cmd)
  );

  pnu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  pnu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_addr  (out_addr),
    .out_word  (out_word),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== rtl/core/pnu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pnu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 62
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pnu_front.sv =====
// Front end: configuration registers, map position tracking and request classification.
module pnu_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pnu_pkg::PADDR_BITS-1:0] paddr,
  input  logic [pnu_pkg::PDATA_BITS-1:0] pwdata,
  output logic [pnu_pkg::PDATA_BITS-1:0] prdata,
  input  logic                         in_fire,
  input  logic [pnu_pkg::WORD_BITS-1:0] in_word,
  output pnu_pkg::cmd_t                cmd
);
  import pnu_pkg::*;

  logic [WIDTH_BITS-1:0] row_width;
  logic [CCNT_BITS-1:0]  channel_count;
  logic [CHAN_BITS-1:0]  chan_index;
  logic [WIDTH_BITS-1:0] row_index;
  logic [WIDTH_BITS-1:0] word_index;
  logic                  odd;
  logic [ADDR_BITS-1:0]  out_row_base;

  logic                  cfg_wr;
  reg_index_t            reg_sel;
  logic [WIDTH_BITS-1:0] size;
  logic [CCNT_BITS-1:0]  eff_chan;
  logic [WIDTH_BITS-1:0] len;
  logic [WIDTH_BITS-1:0] k;
  logic [WIDTH_BITS:0]   i0;
  logic [WIDTH_BITS:0]   i1;
  logic                  valid0;
  logic                  valid1;
  logic                  replay;
  logic                  row_wrap;
  logic                  map_end;
  logic [HALF_BITS-1:0]  half0;
  logic [HALF_BITS-1:0]  half1;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_ROW_WIDTH:  prdata = PDATA_BITS'(row_width);
      REG_CHAN_COUNT: prdata = PDATA_BITS'(channel_count);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (row_width == '0) begin
      size = WIDTH_BITS'(1);
    end else if (row_width > WIDTH_BITS'(MAX_WIDTH)) begin
      size = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      size = row_width;
    end
    if (channel_count == '0) begin
      eff_chan = CCNT_BITS'(1);
    end else if (channel_count > CCNT_BITS'(CHAN_LIMIT)) begin
      eff_chan = CCNT_BITS'(CHAN_LIMIT);
    end else begin
      eff_chan = channel_count;
    end
  end

  always_comb begin
    len      = WIDTH_BITS'(({1'b0, size} + (WIDTH_BITS+1)'(odd) + (WIDTH_BITS+1)'(1)) >> 1);
    k        = (word_index >= len) ? '0 : word_index;
    i0       = {k, 1'b0} - (WIDTH_BITS+1)'(odd);
    i1       = {k, 1'b0} + (WIDTH_BITS+1)'(1) - (WIDTH_BITS+1)'(odd);
    valid0   = !((k == '0) && odd) && (i0 < {1'b0, size});
    valid1   = i1 < {1'b0, size};
    replay   = k == len - WIDTH_BITS'(1);
    row_wrap = ({1'b0, row_index} + (WIDTH_BITS+1)'(1)) >= {1'b0, size};
    map_end  = row_wrap && ((CCNT_BITS'(chan_index) + CCNT_BITS'(1)) >= eff_chan);
    half0    = in_word[HALF_BITS-1:0] & SAMPLE_MASK;
    half1    = in_word[WORD_BITS-1:HALF_BITS] & SAMPLE_MASK;
  end

  always_comb begin
    cmd.sample_a = valid0 ? half0 : half1;
    cmd.sample_b = half1;
    cmd.two      = valid0 && valid1;
    cmd.idx_a    = valid0 ? IDX_BITS'(i0) : IDX_BITS'(i1);
    cmd.size     = size;
    cmd.row_base = out_row_base;
    cmd.replay   = replay;
    cmd.done     = replay && map_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= WIDTH_BITS'(13);
      channel_count <= CCNT_BITS'(128);
      chan_index    <= '0;
      row_index     <= '0;
      word_index    <= '0;
      odd           <= 1'b0;
      out_row_base  <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROW_WIDTH:  row_width <= pwdata[WIDTH_BITS-1:0];
        REG_CHAN_COUNT: channel_count <= pwdata[CCNT_BITS-1:0];
        default: ;
      endcase
      chan_index   <= '0;
      row_index    <= '0;
      word_index   <= '0;
      odd          <= 1'b0;
      out_row_base <= '0;
    end else if (in_fire) begin
      if (replay) begin
        word_index <= '0;
        if (map_end) begin
          chan_index   <= '0;
          row_index    <= '0;
          odd          <= 1'b0;
          out_row_base <= '0;
        end else begin
          odd          <= odd ^ size[0];
          out_row_base <= out_row_base + ADDR_BITS'({size, 1'b0});
          if (row_wrap) begin
            row_index  <= '0;
            chan_index <= chan_index + CHAN_BITS'(1);
          end else begin
            row_index <= row_index + WIDTH_BITS'(1);
          end
        end
      end else begin
        word_index <= k + WIDTH_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/core/pnu_queue.sv =====
// Short request queue between the front end and the back end.
module pnu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pnu_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pnu_pkg::cmd_t head_cmd
);
  import pnu_pkg::*;

  localparam int PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

  cmd_t                entries [Q_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full       = count == CNT_BITS'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end
  end

endmodule

// ===== rtl/core/pnu_back.sv =====
// Back end: emits sample results, fills the line store and replays the odd output row.
module pnu_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  pnu_pkg::cmd_t                 head_cmd,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pnu_pkg::ADDR_BITS-1:0] out_addr,
  output logic [pnu_pkg::WORD_BITS-1:0] out_word,
  output logic                          m_tlast,
  output logic                          m_tuser
);
  import pnu_pkg::*;

  typedef enum logic [1:0] {
    ST_SAMPLE,
    ST_READ,
    ST_REPLAY
  } state_t;

  state_t                state;
  logic                  sel;
  logic [IDX_BITS-1:0]   rep_idx;
  logic [ADDR_BITS-1:0]  rep_addr;

  logic                  slot_free;
  logic                  last_sample;
  logic                  last_replay;
  logic [HALF_BITS-1:0]  cur_sample;
  logic [IDX_BITS-1:0]   cur_idx;
  logic                  ram_we;
  logic                  ram_re;
  logic [IDX_BITS-1:0]   ram_raddr;
  logic [HALF_BITS-1:0]  ram_rdata;
  logic                  emit;

  assign slot_free   = !m_tvalid || m_tready;
  assign last_sample = !head_cmd.two || sel;
  assign last_replay = rep_idx == IDX_BITS'(head_cmd.size - WIDTH_BITS'(1));
  assign cur_sample  = sel ? head_cmd.sample_b : head_cmd.sample_a;
  assign cur_idx     = head_cmd.idx_a + IDX_BITS'(sel);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    pop       = 1'b0;
    emit      = 1'b0;
    case (state)
      ST_SAMPLE: begin
        ram_we = head_valid && slot_free;
        emit   = head_valid && slot_free;
        pop    = head_valid && slot_free && last_sample && !head_cmd.replay;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_REPLAY: begin
        if (slot_free) begin
          emit      = 1'b1;
          pop       = last_replay;
          ram_re    = !last_replay;
          ram_raddr = rep_idx + IDX_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  pnu_ram #(
    .WIDTH(HALF_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_idx),
    .wdata(cur_sample),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SAMPLE;
      sel      <= 1'b0;
      rep_idx  <= '0;
      rep_addr <= '0;
      m_tvalid <= 1'b0;
      out_addr <= '0;
      out_word <= '0;
      m_tlast  <= 1'b0;
      m_tuser  <= 1'b0;
    end else begin
      m_tvalid <= emit || (m_tvalid && !m_tready);
      case (state)
        ST_SAMPLE: begin
          if (head_valid && slot_free) begin
            out_addr <= head_cmd.row_base + ADDR_BITS'(cur_idx);
            out_word <= {cur_sample, cur_sample};
            m_tlast  <= last_sample && !head_cmd.replay;
            m_tuser  <= 1'b0;
            if (last_sample) begin
              sel <= 1'b0;
              if (head_cmd.replay) begin
                state <= ST_READ;
              end
            end else begin
              sel <= 1'b1;
            end
          end
        end
        ST_READ: begin
          rep_idx  <= '0;
          rep_addr <= head_cmd.row_base + ADDR_BITS'(head_cmd.size);
          state    <= ST_REPLAY;
        end
        ST_REPLAY: begin
          if (slot_free) begin
            out_addr <= rep_addr;
            out_word <= {ram_rdata, ram_rdata};
            m_tlast  <= last_replay;
            m_tuser  <= last_replay && head_cmd.done;
            if (last_replay) begin
              state <= ST_SAMPLE;
            end else begin
              rep_idx  <= rep_idx + IDX_BITS'(1);
              rep_addr <= rep_addr + ADDR_BITS'(1);
            end
          end
        end
        default: state <= ST_SAMPLE;
      endcase
    end
  end

endmodule

// ===== dv/pnu_checker.sv =====
`timescale 1ns / 1ps
// Checker for the packed upsampler: tracks register writes, predicts results and compares them.
module pnu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] in_word
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // [23:0] out_addr, [55:24] out_word
  input  logic        m_tlast,
  input  logic        m_tuser,   // [0] map_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          maps_seen
);
  import pnu_pkg::*;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0] data;
    logic                 last;
    logic                 done;
  } up_beat_t;

  up_beat_t              expected_beats[$];
  logic [HALF_BITS-1:0]  row_copy [MAX_WIDTH];
  logic [WIDTH_BITS-1:0] width_reg;
  logic [CCNT_BITS-1:0]  chan_reg;
  int unsigned           chan_pos;
  int unsigned           row_pos;
  int unsigned           word_pos;
  logic [ADDR_BITS-1:0]  row_start;
  logic [ADDR_BITS-1:0]  row_base;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    maps_seen    = 0;
  end

  function automatic int unsigned active_width();
    int unsigned w;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned active_channels();
    int unsigned c;
    c = int'(chan_reg);
    if (c < 1) c = 1;
    if (c > CHAN_LIMIT) c = CHAN_LIMIT;
    return c;
  endfunction

  task automatic restart_map();
    chan_pos  = 0;
    row_pos   = 0;
    word_pos  = 0;
    row_start = '0;
    row_base  = '0;
  endtask

  task automatic push_beat(input int unsigned addr, input logic [HALF_BITS-1:0] s);
    up_beat_t b;
    b.addr = ADDR_BITS'(addr);
    b.data = {s, s};
    b.last = 1'b0;
    b.done = 1'b0;
    expected_beats.push_back(b);
  endtask

  task automatic predict_upsample(input logic [WORD_BITS-1:0] w);
    int unsigned size, odd, first, last_word, len, k, j;
    int idx, h;
    logic [HALF_BITS-1:0] s;
    logic map_end;
    up_beat_t tail;
    size      = active_width();
    odd       = int'(row_start[0]);
    first     = int'(row_start) >> 1;
    last_word = (int'(row_start) + size - 1) >> 1;
    len       = last_word - first + 1;
    map_end   = 1'b0;
    if (word_pos >= len) word_pos = 0;
    k = word_pos;
    for (h = 0; h < 2; h++) begin
      idx = int'(2 * k) + h - int'(odd);
      if (idx >= 0 && idx < int'(size)) begin
        s = w[HALF_BITS*h +: HALF_BITS] & SAMPLE_MASK;
        row_copy[idx] = s;
        push_beat(int'(row_base) + idx, s);
      end
    end
    if (k == len - 1) begin
      for (j = 0; j < size; j++) push_beat(int'(row_base) + size + j, row_copy[j]);
      word_pos  = 0;
      row_start = ADDR_BITS'(int'(row_start) + size);
      row_base  = ADDR_BITS'(int'(row_base) + 2 * size);
      row_pos++;
      if (row_pos >= size) begin
        row_pos = 0;
        chan_pos++;
        if (chan_pos >= active_channels()) begin
          restart_map();
          map_end = 1'b1;
        end
      end
    end else begin
      word_pos = k + 1;
    end
    tail = expected_beats.pop_back();
    tail.last = 1'b1;
    tail.done = map_end;
    expected_beats.push_back(tail);
  endtask

  task automatic check_beat();
    up_beat_t want, got;
    got = {m_tdata[23:0], m_tdata[55:24], m_tlast, m_tuser};
    results_seen++;
    if (got.done) maps_seen++;
    if (expected_beats.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result addr %h word %h last %b done %b",
               $time, got.addr, got.data, got.last, got.done);
    end else begin
      want = expected_beats.pop_front();
      if (got !== want) begin
        fail_count++;
        $display("%0t: result mismatch: expected addr %h word %h last %b done %b",
                 $time, want.addr, want.data, want.last, want.done);
        $display("%0t:                  actual   addr %h word %h last %b done %b",
                 $time, got.addr, got.data, got.last, got.done);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_BITS'(13);
      chan_reg  = CCNT_BITS'(128);
      restart_map();
      expected_beats.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (psel && penable && pwrite && pready) begin
        if (reg_index_t'(paddr[2]) == REG_ROW_WIDTH) begin
          width_reg = pwdata[WIDTH_BITS-1:0];
        end else begin
          chan_reg = pwdata[CCNT_BITS-1:0];
        end
        restart_map();
      end
      if (s_tvalid && s_tready) predict_upsample(s_tdata);
    end
    pending = expected_beats.size();
  end

endmodule

// ===== dv/tb_packed_nearest_upsample_2x.sv =====
`timescale 1ns / 1ps
// Testbench top for the packed upsampler: clock, reset, stimulus, register writes and verdict.
module tb_packed_nearest_upsample_2x;
  import pnu_pkg::*;

  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          results_seen;
  int          maps_seen;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          words_sent;
  logic [31:0] edge_words [8];

  packed_nearest_upsample_2x dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pnu_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .maps_seen    (maps_seen)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic drain(input int extra);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    drain(SETTLE_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] width_val, input logic [31:0] chan_val,
                           input int n, input int send_pct, input int recv_pct);
    write_reg(REG_ROW_WIDTH, width_val);
    write_reg(REG_CHAN_COUNT, chan_val);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      // Halfway through, hold requests back until the pipeline is empty.
      if (i == n / 2) drain(0);
      send_word($urandom());
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    words_sent     = 0;
    edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
                   32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_0001, 32'h7FFF_FFFE};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: the second row of width 13 starts on an odd sample.
    foreach (edge_words[i]) send_word(edge_words[i]);
    repeat (6) send_word($urandom());

    // Single-sample rows, two channels: every second word ends the map.
    write_reg(REG_ROW_WIDTH, 32'd1);
    write_reg(REG_CHAN_COUNT, 32'd2);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h1234_ABCD);
    send_word($urandom());

    // Zero in both registers is clamped to one.
    write_reg(REG_ROW_WIDTH, 32'hFFFF_FFC0);
    write_reg(REG_CHAN_COUNT, 32'hFFFF_F800);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);

    // Values above the limits are clamped to the maximum.
    write_reg(REG_ROW_WIDTH, 32'h0000_003F);
    write_reg(REG_CHAN_COUNT, 32'h0000_07FF);
    send_word(32'hFFFF_0000);
    send_word(32'h0000_FFFF);

    run_phase(32'd63, 32'd1024, 40, 0, 0);
    run_phase(32'd5, 32'd2, 35, 86, 0);
    run_phase(32'd3, $urandom_range(1, 3), 35, 0, 86);
    run_phase(32'd1, 32'd1, 20, 34, 34);
    run_phase($urandom_range(1, 8), $urandom_range(1, 4), 40, 34, 34);
    run_phase(32'd62, 32'd1, 40, 0, 86);

    drain(20);
    $display("Sent %0d input words and checked %0d results, %0d of them closing a map.",
             words_sent, results_seen, maps_seen);
    $display("Widths from 1 to 62 and channel counts from 1 to 1024 under four stall mixes.");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
